// ----- hdl/fqmm_pkg.sv -----
// ----------------------------------------------------------------------------
// fqmm_pkg
// Shared constants, types and helpers for the FIFO queue with min/max report.
// ----------------------------------------------------------------------------
package fqmm_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic F_INSERT  = 1'b0;
  localparam logic F_EXTRACT = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  localparam data_t MIN_IDENT = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam data_t MAX_IDENT = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic signed [31:0] NEG_ONE = '1;

  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
  } cell_ctl_t;

  function automatic data_t to_data(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] to_out(input data_t d);
    logic signed [63:0] w;
    w = 64'(d);
    return w[31:0];
  endfunction

endpackage

// ----- hdl/fqmm_cell.sv -----
// ----------------------------------------------------------------------------
// fqmm_cell
// One queue slot: holds an entry, shifts toward the head on extract, and
// passes a running min/max to the next slot during the scan.
// ----------------------------------------------------------------------------
module fqmm_cell (
  input  logic                clk,
  input  fqmm_pkg::cell_ctl_t ctl,
  input  fqmm_pkg::cnt_t      fill,
  input  fqmm_pkg::cnt_t      slot,
  input  fqmm_pkg::data_t     din,
  input  fqmm_pkg::data_t     nxt,
  input  fqmm_pkg::data_t     pmin_in,
  input  fqmm_pkg::data_t     pmax_in,
  output fqmm_pkg::data_t     entry,
  output fqmm_pkg::data_t     pmin,
  output fqmm_pkg::data_t     pmax
);

  logic occ;

  assign occ = slot < fill;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= nxt;
    end else if (ctl.load && (fill == slot)) begin
      entry <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      pmin <= (occ && (entry < pmin_in)) ? entry : pmin_in;
      pmax <= (occ && (entry > pmax_in)) ? entry : pmax_in;
    end
  end

endmodule

// ----- hdl/fifo_queue_min_max_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_min_max_unit
// Bounded FIFO of signed values held in a chain of shifting cells, with
// front, min, max and count reported after every insert or extract.
//
//   channel | signals                              | dir
//   in      | in_valid, in_ready, func, value      | sink
//   out     | out_valid, out_ready, taken_value,   | source
//           | underflow, overflow, front_value,    |
//           | min_value, max_value, count,         |
//           | empty_res                            |
//
// Each beat first updates the cells, then lets the min/max ripple down the
// cell chain, and finally registers the result in the output register.
// A new beat is taken while the previous result waits in the output register;
// a result ready before the output is free holds at the end of the scan.
// Synchronous reset empties the queue; entry storage is not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_min_max_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] taken_value,
  output logic               underflow,
  output logic               overflow,
  output logic signed [31:0] front_value,
  output logic signed [31:0] min_value,
  output logic signed [31:0] max_value,
  output logic [7:0]         count,
  output logic               empty_res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state;
  fqmm_pkg::cnt_t      scan_cnt;
  fqmm_pkg::cnt_t      fill;
  logic signed [31:0]  taken_r;
  logic                under_r;
  logic                over_r;

  logic                acc;
  logic                is_full;
  logic                is_empty;
  logic                publish;
  logic [63:0]         fill_wide;
  fqmm_pkg::cell_ctl_t ctl;
  fqmm_pkg::data_t     din;

  fqmm_pkg::data_t entry_w [fqmm_pkg::DEPTH];
  fqmm_pkg::data_t pmin_w  [fqmm_pkg::DEPTH];
  fqmm_pkg::data_t pmax_w  [fqmm_pkg::DEPTH];

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign is_full   = (fill == fqmm_pkg::CNT_W'(fqmm_pkg::DEPTH));
  assign is_empty  = (fill == '0);
  assign din       = fqmm_pkg::to_data(value);
  assign fill_wide = 64'(fill);

  assign ctl.load  = acc && (func == fqmm_pkg::F_INSERT) && !is_full;
  assign ctl.shift = acc && (func == fqmm_pkg::F_EXTRACT) && !is_empty;
  assign ctl.scan  = (state == S_SCAN) && (scan_cnt != '0);
  assign publish   = (state == S_SCAN) && (scan_cnt == '0) && (!out_valid || out_ready);

  for (genvar i = 0; i < fqmm_pkg::DEPTH; i++) begin : g_cell
    fqmm_pkg::data_t nxt_i;
    fqmm_pkg::data_t pmin_i;
    fqmm_pkg::data_t pmax_i;

    if (i == fqmm_pkg::DEPTH - 1) begin : g_last
      assign nxt_i = entry_w[i];
    end else begin : g_mid
      assign nxt_i = entry_w[i+1];
    end

    if (i == 0) begin : g_first
      assign pmin_i = fqmm_pkg::MIN_IDENT;
      assign pmax_i = fqmm_pkg::MAX_IDENT;
    end else begin : g_rest
      assign pmin_i = pmin_w[i-1];
      assign pmax_i = pmax_w[i-1];
    end

    fqmm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .fill    (fill),
      .slot    (fqmm_pkg::CNT_W'(i)),
      .din     (din),
      .nxt     (nxt_i),
      .pmin_in (pmin_i),
      .pmax_in (pmax_i),
      .entry   (entry_w[i]),
      .pmin    (pmin_w[i]),
      .pmax    (pmax_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        state    <= S_SCAN;
        scan_cnt <= fqmm_pkg::CNT_W'(fqmm_pkg::DEPTH);
        if (ctl.load) begin
          fill <= fill + 1'b1;
        end else if (ctl.shift) begin
          fill <= fill - 1'b1;
        end
      end else if (ctl.scan) begin
        scan_cnt <= scan_cnt - 1'b1;
      end

      if (publish) begin
        state     <= S_IDLE;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      taken_r <= ctl.shift ? fqmm_pkg::to_out(entry_w[0]) : fqmm_pkg::NEG_ONE;
      under_r <= (func == fqmm_pkg::F_EXTRACT) && is_empty;
      over_r  <= (func == fqmm_pkg::F_INSERT) && is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      taken_value <= taken_r;
      underflow   <= under_r;
      overflow    <= over_r;
      count       <= fill_wide[7:0];
      empty_res   <= is_empty;
      if (is_empty) begin
        front_value <= fqmm_pkg::NEG_ONE;
        min_value   <= fqmm_pkg::NEG_ONE;
        max_value   <= fqmm_pkg::NEG_ONE;
      end else begin
        front_value <= fqmm_pkg::to_out(entry_w[0]);
        min_value   <= fqmm_pkg::to_out(pmin_w[fqmm_pkg::DEPTH-1]);
        max_value   <= fqmm_pkg::to_out(pmax_w[fqmm_pkg::DEPTH-1]);
      end
    end
  end

`ifndef ASSERT_OFF
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == fqmm_pkg::F_INSERT) && is_full) |=> $stable(fill))
    else $error("insert on full queue changed fill");

  a_extract_dec: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == fqmm_pkg::F_EXTRACT) && !is_empty) |=> (fill == $past(fill) - 1'b1))
    else $error("extract did not remove one entry");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    acc |=> ((state == S_SCAN) && (scan_cnt == fqmm_pkg::CNT_W'(fqmm_pkg::DEPTH))))
    else $error("scan did not start after accepted beat");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (empty_res == (fill == '0)))
    else $error("empty flag disagrees with fill count");
`endif

endmodule
